// ===== hw/rtl/btl_pkg.sv =====
package btl_pkg;

    // Field widths
    localparam int VIN_W      = 16;   // cell voltage input, mV
    localparam int MV_W       = 13;   // threshold registers, mV
    localparam int CUR_W      = 10;   // currents, dA
    localparam int CFG_W      = 20;   // widest register
    localparam int CFG_IDX_W  = 3;
    localparam int STAT_W     = 2;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;

    // Datapath widths: spans stay below 1700 mV, so 11 bits hold them
    localparam int DIFF_W = 11;
    localparam int DVD_W  = DIFF_W + CUR_W;
    localparam int QUO_W  = CUR_W;

    // Pipeline shape
    localparam int FRONT_STAGES = 2;
    localparam int DIV_BPS      = 2;
    localparam int DIV_STAGES   = QUO_W / DIV_BPS;
    localparam int PIPE_STAGES  = FRONT_STAGES + DIV_STAGES;

    // Fixed limits
    localparam logic [VIN_W-1:0] V_MIN_MV        = 16'd1500;
    localparam logic [VIN_W-1:0] V_MAX_MV        = 16'd4500;
    localparam logic [MV_W-1:0]  V_MAX_CFG_MV    = 13'd4500;
    localparam logic [CUR_W-1:0] CUR_MAX_DA      = 10'd1000;
    localparam logic [MV_W-1:0]  CHG_FULL_MIN_MV = 13'd2500;
    localparam logic [MV_W-1:0]  CHG_STOP_LIM_MV = 13'd4200;
    localparam logic [MV_W-1:0]  DIS_STOP_LIM_MV = 13'd2800;

    // Register reset values
    localparam logic [MV_W-1:0]  RST_CHG_FULL = 13'd3900;
    localparam logic [MV_W-1:0]  RST_CHG_RED  = 13'd4050;
    localparam logic [MV_W-1:0]  RST_CHG_STOP = 13'd4150;
    localparam logic [CFG_W-1:0] RST_CHG_CUR  = 20'd51700;
    localparam logic [MV_W-1:0]  RST_DIS_FULL = 13'd3500;
    localparam logic [MV_W-1:0]  RST_DIS_RED  = 13'd3200;
    localparam logic [MV_W-1:0]  RST_DIS_STOP = 13'd3000;
    localparam logic [CFG_W-1:0] RST_DIS_CUR  = 20'd103400;

    typedef enum logic [CFG_IDX_W-1:0] {
        IDX_CHG_FULL = 3'd0,
        IDX_CHG_RED  = 3'd1,
        IDX_CHG_STOP = 3'd2,
        IDX_CHG_CUR  = 3'd3,
        IDX_DIS_FULL = 3'd4,
        IDX_DIS_RED  = 3'd5,
        IDX_DIS_STOP = 3'd6,
        IDX_DIS_CUR  = 3'd7
    } t_cfg_idx;

    typedef enum logic [STAT_W-1:0] {
        STAT_NORMAL  = 2'd0,
        STAT_BAD_CFG = 2'd1,
        STAT_RANGE   = 2'd2
    } t_status;

    // Where a voltage sits on its taper curve
    typedef enum logic [1:0] {
        RGN_FULL = 2'd0,
        RGN_LERP = 2'd1,
        RGN_RED  = 2'd2,
        RGN_ZERO = 2'd3
    } t_region;

    typedef struct packed {
        logic [MV_W-1:0]  chg_full;
        logic [MV_W-1:0]  chg_red;
        logic [MV_W-1:0]  chg_stop;
        logic [CUR_W-1:0] chg_cf;
        logic [CUR_W-1:0] chg_cr;
        logic [MV_W-1:0]  dis_full;
        logic [MV_W-1:0]  dis_red;
        logic [MV_W-1:0]  dis_stop;
        logic [CUR_W-1:0] dis_df;
        logic [CUR_W-1:0] dis_dr;
        logic             ok;
    } t_cfg;

    // Per-item control carried alongside the divider
    typedef struct packed {
        t_status status;
        t_region chg_rgn;
        t_region dis_rgn;
    } t_side;

    typedef struct packed {
        logic [DVD_W-1:0]  dvd;
        logic [DIFF_W-1:0] dsr;
    } t_div_in;

endpackage

// ===== hw/rtl/btl_cfg.sv =====
module btl_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_we,
    input  logic [btl_pkg::CFG_IDX_W-1:0]  i_addr,
    input  logic [btl_pkg::CFG_W-1:0]      i_wdata,
    output btl_pkg::t_cfg                  o_cfg
);

    logic [btl_pkg::MV_W-1:0]  r_chg_full, r_chg_red, r_chg_stop;
    logic [btl_pkg::MV_W-1:0]  r_dis_full, r_dis_red, r_dis_stop;
    logic [btl_pkg::CFG_W-1:0] r_chg_cur, r_dis_cur;
    logic [btl_pkg::MV_W-1:0]  w_v13;
    logic [btl_pkg::CUR_W-1:0] w_cf, w_cr, w_df, w_dr;
    logic                      w_cur_ok, w_chg_ok, w_dis_ok;

    assign w_v13 = i_wdata[btl_pkg::MV_W-1:0];

    // Register file, write only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chg_full <= btl_pkg::RST_CHG_FULL;
            r_chg_red  <= btl_pkg::RST_CHG_RED;
            r_chg_stop <= btl_pkg::RST_CHG_STOP;
            r_chg_cur  <= btl_pkg::RST_CHG_CUR;
            r_dis_full <= btl_pkg::RST_DIS_FULL;
            r_dis_red  <= btl_pkg::RST_DIS_RED;
            r_dis_stop <= btl_pkg::RST_DIS_STOP;
            r_dis_cur  <= btl_pkg::RST_DIS_CUR;
        end else if (i_we) begin
            case (btl_pkg::t_cfg_idx'(i_addr))
                btl_pkg::IDX_CHG_FULL: r_chg_full <= w_v13;
                btl_pkg::IDX_CHG_RED:  r_chg_red  <= w_v13;
                btl_pkg::IDX_CHG_STOP: r_chg_stop <= w_v13;
                btl_pkg::IDX_CHG_CUR:  r_chg_cur  <= i_wdata;
                btl_pkg::IDX_DIS_FULL: r_dis_full <= w_v13;
                btl_pkg::IDX_DIS_RED:  r_dis_red  <= w_v13;
                btl_pkg::IDX_DIS_STOP: r_dis_stop <= w_v13;
                btl_pkg::IDX_DIS_CUR:  r_dis_cur  <= i_wdata;
                default: ;
            endcase
        end
    end

    // Current pairs split into full and reduced
    assign w_cf = r_chg_cur[btl_pkg::CUR_W-1:0];
    assign w_cr = r_chg_cur[2*btl_pkg::CUR_W-1:btl_pkg::CUR_W];
    assign w_df = r_dis_cur[btl_pkg::CUR_W-1:0];
    assign w_dr = r_dis_cur[2*btl_pkg::CUR_W-1:btl_pkg::CUR_W];

    // Drive the settings record and its validity flag
    always_comb begin
        o_cfg.chg_full = r_chg_full;
        o_cfg.chg_red  = r_chg_red;
        o_cfg.chg_stop = r_chg_stop;
        o_cfg.chg_cf   = w_cf;
        o_cfg.chg_cr   = w_cr;
        o_cfg.dis_full = r_dis_full;
        o_cfg.dis_red  = r_dis_red;
        o_cfg.dis_stop = r_dis_stop;
        o_cfg.dis_df   = w_df;
        o_cfg.dis_dr   = w_dr;
        o_cfg.ok       = w_cur_ok && w_chg_ok && w_dis_ok;
    end

    // Settings validity
    always_comb begin
        w_cur_ok = (w_cf != '0) && (w_cf <= btl_pkg::CUR_MAX_DA) &&
                   (w_cr != '0) && (w_cr <= w_cf) &&
                   (w_df != '0) && (w_df <= btl_pkg::CUR_MAX_DA) &&
                   (w_dr != '0) && (w_dr <= w_df);
        w_chg_ok = (r_chg_full >= btl_pkg::CHG_FULL_MIN_MV) &&
                   (r_chg_full < r_chg_red) && (r_chg_red < r_chg_stop) &&
                   (r_chg_stop < btl_pkg::CHG_STOP_LIM_MV);
        w_dis_ok = (r_dis_stop > btl_pkg::DIS_STOP_LIM_MV) &&
                   (r_dis_stop < r_dis_red) && (r_dis_red < r_dis_full) &&
                   (r_dis_full <= btl_pkg::V_MAX_CFG_MV);
    end

endmodule

// ===== hw/rtl/btl_front.sv =====
module btl_front (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [btl_pkg::VIN_W-1:0]  i_hi_mv,
    input  logic [btl_pkg::VIN_W-1:0]  i_lo_mv,
    input  btl_pkg::t_cfg              i_cfg,
    output btl_pkg::t_side             o_side,
    output btl_pkg::t_div_in           o_chg_div,
    output btl_pkg::t_div_in           o_dis_div
);

    typedef struct packed {
        btl_pkg::t_side              side;
        logic [btl_pkg::DIFF_W-1:0]  chg_x;
        logic [btl_pkg::CUR_W-1:0]   chg_dy;
        logic [btl_pkg::DIFF_W-1:0]  chg_den;
        logic [btl_pkg::DIFF_W-1:0]  dis_x;
        logic [btl_pkg::CUR_W-1:0]   dis_dy;
        logic [btl_pkg::DIFF_W-1:0]  dis_den;
    } t_stage_a;

    t_stage_a         n_a, r_a;
    btl_pkg::t_side   r_b_side;
    btl_pkg::t_div_in n_b_chg, n_b_dis, r_b_chg, r_b_dis;

    logic [btl_pkg::VIN_W-1:0] w_chg_full, w_chg_red, w_chg_stop;
    logic [btl_pkg::VIN_W-1:0] w_dis_full, w_dis_red, w_dis_stop;

    assign w_chg_full = btl_pkg::VIN_W'(i_cfg.chg_full);
    assign w_chg_red  = btl_pkg::VIN_W'(i_cfg.chg_red);
    assign w_chg_stop = btl_pkg::VIN_W'(i_cfg.chg_stop);
    assign w_dis_full = btl_pkg::VIN_W'(i_cfg.dis_full);
    assign w_dis_red  = btl_pkg::VIN_W'(i_cfg.dis_red);
    assign w_dis_stop = btl_pkg::VIN_W'(i_cfg.dis_stop);

    // Stage A: status, curve region, spans and offsets
    always_comb begin
        if (!i_cfg.ok) begin
            n_a.side.status = btl_pkg::STAT_BAD_CFG;
        end else if (i_hi_mv < btl_pkg::V_MIN_MV || i_hi_mv > btl_pkg::V_MAX_MV ||
                     i_lo_mv < btl_pkg::V_MIN_MV || i_lo_mv > btl_pkg::V_MAX_MV) begin
            n_a.side.status = btl_pkg::STAT_RANGE;
        end else begin
            n_a.side.status = btl_pkg::STAT_NORMAL;
        end

        if (i_hi_mv >= w_chg_stop) begin
            n_a.side.chg_rgn = btl_pkg::RGN_ZERO;
        end else if (i_hi_mv >= w_chg_red) begin
            n_a.side.chg_rgn = btl_pkg::RGN_RED;
        end else if (i_hi_mv > w_chg_full) begin
            n_a.side.chg_rgn = btl_pkg::RGN_LERP;
        end else begin
            n_a.side.chg_rgn = btl_pkg::RGN_FULL;
        end

        if (i_lo_mv <= w_dis_stop) begin
            n_a.side.dis_rgn = btl_pkg::RGN_ZERO;
        end else if (i_lo_mv <= w_dis_red) begin
            n_a.side.dis_rgn = btl_pkg::RGN_RED;
        end else if (i_lo_mv < w_dis_full) begin
            n_a.side.dis_rgn = btl_pkg::RGN_LERP;
        end else begin
            n_a.side.dis_rgn = btl_pkg::RGN_FULL;
        end

        // only meaningful inside the interpolation span, where they fit
        n_a.chg_x   = btl_pkg::DIFF_W'(i_hi_mv - w_chg_full);
        n_a.chg_dy  = i_cfg.chg_cf - i_cfg.chg_cr;
        n_a.chg_den = btl_pkg::DIFF_W'(i_cfg.chg_red - i_cfg.chg_full);
        n_a.dis_x   = btl_pkg::DIFF_W'(i_lo_mv - w_dis_red);
        n_a.dis_dy  = i_cfg.dis_df - i_cfg.dis_dr;
        n_a.dis_den = btl_pkg::DIFF_W'(i_cfg.dis_full - i_cfg.dis_red);
    end

    // Stage B: span product plus half the divisor for rounding
    always_comb begin
        n_b_chg.dvd = btl_pkg::DVD_W'(r_a.chg_x) * btl_pkg::DVD_W'(r_a.chg_dy)
                    + btl_pkg::DVD_W'(r_a.chg_den >> 1);
        n_b_chg.dsr = r_a.chg_den;
        n_b_dis.dvd = btl_pkg::DVD_W'(r_a.dis_x) * btl_pkg::DVD_W'(r_a.dis_dy)
                    + btl_pkg::DVD_W'(r_a.dis_den >> 1);
        n_b_dis.dsr = r_a.dis_den;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a      <= n_a;
            r_b_side <= r_a.side;
            r_b_chg  <= n_b_chg;
            r_b_dis  <= n_b_dis;
        end
    end

    assign o_side    = r_b_side;
    assign o_chg_div = r_b_chg;
    assign o_dis_div = r_b_dis;

endmodule

// ===== hw/rtl/btl_div.sv =====
module btl_div (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  btl_pkg::t_div_in           i_div,
    output logic [btl_pkg::QUO_W-1:0]  o_quo
);

    localparam int ST  = btl_pkg::DIV_STAGES;
    localparam int BPS = btl_pkg::DIV_BPS;

    logic [btl_pkg::DVD_W-1:0]  r_rem [ST];
    logic [btl_pkg::QUO_W-1:0]  r_quo [ST];
    logic [btl_pkg::DIFF_W-1:0] r_dsr [ST];

    // Restoring division, BPS quotient bits per stage, MSB first
    for (genvar s = 0; s < ST; s++) begin : g_stage
        localparam int B0 = btl_pkg::QUO_W - 1 - s * BPS;

        logic [btl_pkg::DVD_W-1:0]  w_rem_in, n_rem, w_trial;
        logic [btl_pkg::QUO_W-1:0]  w_quo_in, n_quo;
        logic [btl_pkg::DIFF_W-1:0] w_dsr_in;

        if (s == 0) begin : g_first
            assign w_rem_in = i_div.dvd;
            assign w_quo_in = '0;
            assign w_dsr_in = i_div.dsr;
        end else begin : g_next
            assign w_rem_in = r_rem[s-1];
            assign w_quo_in = r_quo[s-1];
            assign w_dsr_in = r_dsr[s-1];
        end

        always_comb begin
            n_rem   = w_rem_in;
            n_quo   = w_quo_in;
            w_trial = '0;
            for (int k = 0; k < BPS; k++) begin
                w_trial = btl_pkg::DVD_W'(w_dsr_in) << (B0 - k);
                if (n_rem >= w_trial) begin
                    n_rem         = n_rem - w_trial;
                    n_quo[B0 - k] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_quo[s] <= n_quo;
                r_dsr[s] <= w_dsr_in;
            end
        end
    end

    assign o_quo = r_quo[ST-1];

endmodule

// ===== hw/rtl/battery_current_taper_limits_top.sv =====
// Battery current taper limits: cell voltages in, charge/discharge limits out.
// Each transaction passes 8 register stages (region decode, span multiply,
// 5 divider stages, output register). Throughput: one transaction per cycle;
// the whole pipeline holds while the output register is full and not taken.
// Reset (synchronous, active low) empties the pipeline and loads the default
// settings.
module battery_current_taper_limits_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // [15:0] highest_cell_mv, [31:16] lowest_cell_mv
    input  logic [btl_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [9:0] charge_limit_da, [19:10] discharge_limit_da, [21:20] limit_status
    output logic [btl_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic                                 i_cfg_we,
    input  logic [btl_pkg::CFG_IDX_W-1:0]        i_cfg_addr,
    input  logic [btl_pkg::CFG_W-1:0]            i_cfg_wdata
);

    localparam int NV = btl_pkg::PIPE_STAGES;
    localparam int ST = btl_pkg::DIV_STAGES;

    btl_pkg::t_cfg    w_cfg;
    btl_pkg::t_side   w_front_side;
    btl_pkg::t_div_in w_chg_div, w_dis_div;
    logic [btl_pkg::QUO_W-1:0] w_chg_q, w_dis_q;
    logic             w_adv;

    logic [NV-1:0]    r_vld;
    btl_pkg::t_side   r_side [ST];
    logic             r_out_vld;
    logic [btl_pkg::CUR_W-1:0] n_chg, n_dis, r_chg, r_dis;
    btl_pkg::t_status r_status;

    // Whole pipeline moves unless the output holds an untaken result
    assign w_adv         = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_adv;

    btl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_addr  (i_cfg_addr),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (w_cfg)
    );

    btl_front u_front (
        .i_clk     (i_clk),
        .i_en      (w_adv),
        .i_hi_mv   (s_axis_tdata[btl_pkg::VIN_W-1:0]),
        .i_lo_mv   (s_axis_tdata[2*btl_pkg::VIN_W-1:btl_pkg::VIN_W]),
        .i_cfg     (w_cfg),
        .o_side    (w_front_side),
        .o_chg_div (w_chg_div),
        .o_dis_div (w_dis_div)
    );

    btl_div u_chg_div (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_div (w_chg_div),
        .o_quo (w_chg_q)
    );

    btl_div u_dis_div (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_div (w_dis_div),
        .o_quo (w_dis_q)
    );

    // Valid bits, one per stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_vld     <= {r_vld[NV-2:0], s_axis_tvalid};
            r_out_vld <= r_vld[NV-1];
        end
    end

    // Control travels beside the dividers
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side[0] <= w_front_side;
            for (int i = 1; i < ST; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    // Final selection on the taper curve
    always_comb begin
        case (r_side[ST-1].chg_rgn)
            btl_pkg::RGN_FULL: n_chg = w_cfg.chg_cf;
            btl_pkg::RGN_LERP: n_chg = w_cfg.chg_cf - w_chg_q;
            btl_pkg::RGN_RED:  n_chg = w_cfg.chg_cr;
            btl_pkg::RGN_ZERO: n_chg = '0;
            default:           n_chg = '0;
        endcase
        case (r_side[ST-1].dis_rgn)
            btl_pkg::RGN_FULL: n_dis = w_cfg.dis_df;
            btl_pkg::RGN_LERP: n_dis = w_cfg.dis_dr + w_dis_q;
            btl_pkg::RGN_RED:  n_dis = w_cfg.dis_dr;
            btl_pkg::RGN_ZERO: n_dis = '0;
            default:           n_dis = '0;
        endcase
        if (r_side[ST-1].status != btl_pkg::STAT_NORMAL) begin
            n_chg = '0;
            n_dis = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_chg    <= n_chg;
            r_dis    <= n_dis;
            r_status <= r_side[ST-1].status;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {2'b00, r_status, r_dis, r_chg};

    // A fault result carries zero limits
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_status != btl_pkg::STAT_NORMAL) |-> (r_chg == '0 && r_dis == '0))
        else $error("fault result with non-zero limit");

    // A stall freezes the valid bits of every stage
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_adv) |=> ($stable(r_vld) && $stable(r_out_vld)))
        else $error("pipeline moved during stall");

    // The last stage always lands in the output register
    a_last_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NV-1] && w_adv) |=> r_out_vld)
        else $error("transaction lost before output");

endmodule
